// ----- hdl/smmf_pkg.sv -----
// Package for the stack median/mean fuser: shared constants, the divider
// state type and the divider status struct.
// No dependencies.
`timescale 1ns / 1ps

package smmf_pkg;

  // Default depth of the sorting chain and default sample width.
  localparam int MAX_IMAGES_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Width of the image count register, fixed by the register map.
  localparam int COUNT_W = 6;

  // Fractional bits of the mean.
  localparam int FRAC_W = 4;

  // States of the mean divider.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // Status that the divider reports to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hdl/smmf_cell.sv -----
// One cell of the sorted insertion chain: holds one sample of the current pixel.
// Standalone module, no package dependencies.
`timescale 1ns / 1ps

module smmf_cell #(
  parameter int IDX         = 0,
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 6
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic [SAMPLE_BITS-1:0] smp,
  input  logic [CNT_W-1:0]       seen,
  input  logic [CNT_W-1:0]       half,
  input  logic                   odd,
  input  logic [SAMPLE_BITS-1:0] prev_val,
  input  logic                   prev_ins,
  output logic [SAMPLE_BITS-1:0] val_o,
  output logic                   ins_o,
  output logic [SAMPLE_BITS-1:0] hi_o,
  output logic [SAMPLE_BITS-1:0] lo_o
);

  logic [SAMPLE_BITS-1:0] val_r;
  logic [SAMPLE_BITS-1:0] val_nxt;
  logic                   occ;

  // A cell beyond the samples seen so far acts as holding an infinite value.
  assign occ   = (CNT_W'(IDX) < seen);
  assign ins_o = !occ || (val_r > smp);

  // Keep the value, take the lower neighbor's value, or take the new sample.
  always_comb begin
    if (!ins_o) begin
      val_nxt = val_r;
    end else if (prev_ins) begin
      val_nxt = prev_val;
    end else begin
      val_nxt = smp;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= val_nxt;
    end
  end

  assign val_o = val_r;

  // Offer the value when this cell holds one of the middle samples.
  assign hi_o = (CNT_W'(IDX) == half) ? val_r : '0;
  assign lo_o = (!odd && (CNT_W'(IDX + 1) == half)) ? val_r : '0;

endmodule

// ----- hdl/smmf_div.sv -----
// Restoring divider for the mean: one quotient bit per cycle.
// Depends on smmf_pkg for the state type and the status struct.
`timescale 1ns / 1ps

module smmf_div
  import smmf_pkg::*;
#(
  parameter int DVD_W = 25,
  parameter int DVS_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             ack,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  div_state_t         state_r;
  div_state_t         state_nxt;
  logic [STEP_W-1:0]  cnt_r;
  logic [DVD_W-1:0]   q_r;
  logic [DVS_W-1:0]   rem_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [DVS_W:0]     rem_sh;
  logic [DVS_W:0]     diff;
  logic               ge;
  logic               last_step;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_sh    = {rem_r, q_r[DVD_W-1]};
  assign diff      = rem_sh - {1'b0, dvs_r};
  assign ge        = (rem_sh >= {1'b0, dvs_r});
  assign last_step = (cnt_r == STEP_W'(DVD_W - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DIV_IDLE: if (start) state_nxt = DIV_RUN;
      DIV_RUN:  if (last_step) state_nxt = DIV_DONE;
      DIV_DONE: if (ack) state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  // Status outputs.
  always_comb begin
    stat.busy = (state_r != DIV_IDLE);
    stat.done = (state_r == DIV_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: the dividend register turns into the quotient bit by bit.
  always_ff @(posedge clk) begin
    if (state_r == DIV_IDLE && start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= '0;
    end else if (state_r == DIV_RUN) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_r <= cnt_r + STEP_W'(1);
    end
  end

  assign quotient = q_r;

endmodule

// ----- hdl/stack_median_mean_fuser_unit.sv -----
// Stack median/mean fuser: sorted insertion chain plus serial mean divider.
// Throughput: one sample per cycle within a pixel; the input then stalls while the
//   divider runs and until its result is loaded into the output register.
// Reset (rst_n, synchronous, active low): image count 1, partial pixel dropped.
// Depends on smmf_pkg, smmf_cell and smmf_div.
`timescale 1ns / 1ps

module stack_median_mean_fuser_unit
  import smmf_pkg::*;
#(
  parameter int MAX_IMAGES  = MAX_IMAGES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int MED_W      = SAMPLE_BITS + 1,
  localparam int MEAN_W     = SAMPLE_BITS + FRAC_W,
  localparam int OUT_W      = ((MED_W + MEAN_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // Sample stream.
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,   // sample
  // Result stream.
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,  // median_x2, mean_q4
  // Image count register.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_IMAGES + 1);
  localparam int LOG_W = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 0;
  localparam int SUM_W = SAMPLE_BITS + LOG_W;
  localparam int DVD_W = SUM_W + FRAC_W;

  logic [CNT_W-1:0]       n_r;
  logic [CNT_W-1:0]       n_nxt;
  logic [CNT_W-1:0]       seen_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic                   out_tvalid_r;
  logic [MED_W-1:0]       med_r;
  logic [MEAN_W-1:0]      mean_r;
  logic [SAMPLE_BITS-1:0] smp;
  logic                   in_acc;
  logic                   cfg_acc;
  logic                   last;
  logic                   out_load;
  logic [CNT_W-1:0]       half;
  logic                   odd;
  logic [SAMPLE_BITS-1:0] hi_or;
  logic [SAMPLE_BITS-1:0] lo_or;
  logic [MED_W-1:0]       med_x2;
  logic [DVD_W-1:0]       quot;
  div_stat_t              div_stat;

  logic [SAMPLE_BITS-1:0] cell_val [MAX_IMAGES];
  logic                   cell_ins [MAX_IMAGES];
  logic [SAMPLE_BITS-1:0] cell_hi  [MAX_IMAGES];
  logic [SAMPLE_BITS-1:0] cell_lo  [MAX_IMAGES];

  // Handshakes.
  assign smp       = in_tdata[SAMPLE_BITS-1:0];
  assign in_tready = !div_stat.busy;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign last      = ((seen_r + CNT_W'(1)) == n_r);
  assign sum_nxt   = sum_r + SUM_W'(smp);

  // A count of zero acts as one, a count above the chain depth as the depth.
  always_comb begin
    priority if (cfg_data == '0) begin
      n_nxt = CNT_W'(1);
    end else if (int'(cfg_data) > MAX_IMAGES) begin
      n_nxt = CNT_W'(MAX_IMAGES);
    end else begin
      n_nxt = CNT_W'(cfg_data);
    end
  end

  // Count and running sum of the current pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= CNT_W'(1);
      seen_r <= '0;
      sum_r  <= '0;
    end else if (cfg_acc) begin
      n_r    <= n_nxt;
      seen_r <= '0;
      sum_r  <= '0;
    end else if (in_acc) begin
      seen_r <= last ? '0 : seen_r + CNT_W'(1);
      sum_r  <= last ? '0 : sum_nxt;
    end
  end

  // Sorted insertion chain: each cell passes its value and its insert flag up.
  assign half = n_r >> 1;
  assign odd  = n_r[0];

  for (genvar i = 0; i < MAX_IMAGES; i++) begin : g_cell
    if (i == 0) begin : g_first
      smmf_cell #(
        .IDX         (i),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
      ) u_cell (
        .clk      (clk),
        .shift_en (in_acc),
        .smp      (smp),
        .seen     (seen_r),
        .half     (half),
        .odd      (odd),
        .prev_val ('0),
        .prev_ins (1'b0),
        .val_o    (cell_val[i]),
        .ins_o    (cell_ins[i]),
        .hi_o     (cell_hi[i]),
        .lo_o     (cell_lo[i])
      );
    end else begin : g_rest
      smmf_cell #(
        .IDX         (i),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
      ) u_cell (
        .clk      (clk),
        .shift_en (in_acc),
        .smp      (smp),
        .seen     (seen_r),
        .half     (half),
        .odd      (odd),
        .prev_val (cell_val[i-1]),
        .prev_ins (cell_ins[i-1]),
        .val_o    (cell_val[i]),
        .ins_o    (cell_ins[i]),
        .hi_o     (cell_hi[i]),
        .lo_o     (cell_lo[i])
      );
    end
  end

  // Gather the middle samples; at most one cell drives each of them.
  always_comb begin
    hi_or = '0;
    lo_or = '0;
    for (int i = 0; i < MAX_IMAGES; i++) begin
      hi_or = hi_or | cell_hi[i];
      lo_or = lo_or | cell_lo[i];
    end
  end

  assign med_x2 = {1'b0, hi_or} + (odd ? {1'b0, hi_or} : {1'b0, lo_or});

  // Mean divider, started by the last sample of a pixel.
  smmf_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && last),
    .ack      (out_load),
    .dividend ({sum_nxt, FRAC_W'(0)}),
    .divisor  (n_r),
    .quotient (quot),
    .stat     (div_stat)
  );

  // Output register; the chain holds still while the divider runs.
  assign out_load = div_stat.done && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      med_r  <= med_x2;
      mean_r <= quot[MEAN_W-1:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({mean_r, med_r});

`ifndef SYNTHESIS
  // The sample count of a pixel never reaches the image count.
  a_seen_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r < n_r)
    else $error("sample count reached the image count");

  // The last sample of a pixel stops the input while the mean is divided.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last) |=> !in_tready)
    else $error("input still ready after the last sample of a pixel");

  // Loading the output register releases the divider.
  a_load_releases: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (!div_stat.done && out_tvalid))
    else $error("divider result not handed over");

  // A result appears only after a divider run completed.
  a_result_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(div_stat.done))
    else $error("result without a finished division");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench for stack_median_mean_fuser_unit: streams stacks of 16-bit samples,
// predicts the doubled median and Q4 mean of each pixel, and checks every result.
// Depends on smmf_pkg and stack_median_mean_fuser_unit.

module tb;
  import smmf_pkg::*;

  // Divider latency after the last sample, plus some margin for the idle waits.
  localparam int DIV_LAT = 26;
  localparam int SETTLE  = DIV_LAT + 8;
  localparam int N_MAX   = MAX_IMAGES_DEF;

  typedef struct packed {
    logic [16:0] median_x2;
    logic [19:0] mean_q4;
  } fused_px_t;

  // How the samples of one pixel are chosen.
  typedef enum int {
    MIX_UNIFORM,
    MIX_EXTREME,
    MIX_CLUSTER,
    MIX_RISING,
    MIX_FALLING
  } mix_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [15:0]        in_tdata;    // sample
  logic               out_tvalid;
  logic               out_tready;
  logic [39:0]        out_tdata;   // median_x2, mean_q4
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data;

  // Fuser prediction state.
  logic [COUNT_W-1:0] count_reg;
  logic [15:0]        stack_sorted [N_MAX];
  logic [20:0]        stack_sum;
  int unsigned        stack_fill;
  fused_px_t          fused_q[$];

  // Run bookkeeping.
  int mismatches      = 0;
  int pixels_fused    = 0;
  int samples_sent    = 0;
  int cfg_writes      = 0;
  int in_stall_cycles = 0;
  int hold_cycles     = 0;
  int rx_stall        = 0;
  bit steady          = 1'b0;

  stack_median_mean_fuser_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Samples per pixel as the block applies the register.
  function automatic int unsigned stack_depth();
    int unsigned n;
    n = 32'(count_reg);
    if (n == 0) n = 1;
    if (n > N_MAX) n = N_MAX;
    return n;
  endfunction

  // Insert one accepted sample in order; on the last one, queue the fused pixel.
  function automatic void absorb_pixel_sample(input logic [15:0] v);
    int unsigned pos;
    int unsigned n;
    logic [24:0] scaled;
    fused_px_t   res;
    pos = stack_fill;
    while (pos > 0 && stack_sorted[pos-1] > v) begin
      stack_sorted[pos] = stack_sorted[pos-1];
      pos--;
    end
    stack_sorted[pos] = v;
    stack_fill++;
    stack_sum = stack_sum + 21'(v);
    if (stack_fill >= stack_depth()) begin
      n = stack_fill;
      if (n[0]) begin
        res.median_x2 = {stack_sorted[n/2], 1'b0};
      end else begin
        res.median_x2 = 17'(stack_sorted[n/2-1]) + 17'(stack_sorted[n/2]);
      end
      scaled = {stack_sum, 4'b0000};
      res.mean_q4 = 20'(32'(scaled) / n);
      fused_q.push_back(res);
      stack_sum  = '0;
      stack_fill = 0;
    end
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Check every result transfer against the oldest predicted pixel.
  always @(posedge clk) begin
    fused_px_t got;
    fused_px_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.median_x2 = out_tdata[16:0];
      got.mean_q4   = out_tdata[36:17];
      if (fused_q.size() == 0) begin
        flag_mismatch("unexpected result (median_x2)", -1, int'(got.median_x2));
      end else begin
        want = fused_q.pop_front();
        pixels_fused++;
        if (got.median_x2 !== want.median_x2) begin
          flag_mismatch("median_x2", int'(want.median_x2), int'(got.median_x2));
        end
        if (got.mean_q4 !== want.mean_q4) begin
          flag_mismatch("mean_q4", int'(want.mean_q4), int'(got.mean_q4));
        end
      end
    end
  end

  // Count cycles in which the block held off an offered sample.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) in_stall_cycles++;
  end

  // Result receiver: a requested hold first, then always ready in steady mode, else random stalls, mostly short.
  always @(negedge clk) begin
    int roll;
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else if (steady) begin
      out_tready = 1'b1;
    end else if (rx_stall > 0) begin
      out_tready = 1'b0;
      rx_stall--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        out_tready = 1'b0;
        rx_stall   = $urandom_range(0, 3);
      end else if (roll < 12) begin
        out_tready = 1'b0;
        rx_stall   = $urandom_range(20, 80);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one sample after a random gap (none in steady mode) and wait for its transfer.
  task automatic send_pixel_sample(input logic [15:0] v);
    int gap;
    gap = steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      in_tdata  = 16'($urandom);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = v;
    do @(posedge clk); while (!in_tready);
    absorb_pixel_sample(v);
    samples_sent++;
  endtask

  // Stop offering, wait for every predicted pixel, then let the divider settle.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (fused_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the image count while the block is idle.
  task automatic write_count(input logic [COUNT_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    count_reg  = v;
    stack_sum  = '0;
    stack_fill = 0;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = COUNT_W'($urandom);
  endtask

  // Send n samples with the given mix of values.
  task automatic send_stack(input int n, input mix_t mix);
    logic [15:0] base;
    logic [15:0] step;
    logic [15:0] v;
    case (mix)
      MIX_CLUSTER: base = 16'($urandom_range(0, 65532));
      MIX_RISING:  base = 16'($urandom_range(0, 30000));
      MIX_FALLING: base = 16'($urandom_range(35000, 65535));
      default:     base = '0;
    endcase
    step = 16'($urandom_range(0, 1000));
    for (int k = 0; k < n; k++) begin
      case (mix)
        MIX_EXTREME: begin
          case ($urandom_range(0, 3))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            2:       v = 16'h0001;
            default: v = 16'hFFFE;
          endcase
        end
        MIX_CLUSTER: v = base + 16'($urandom_range(0, 3));
        MIX_RISING:  v = base + 16'(k) * step;
        MIX_FALLING: v = base - 16'(k) * step;
        default:     v = 16'($urandom_range(0, 65535));
      endcase
      send_pixel_sample(v);
    end
  endtask

  // Reset count of one image: every sample is its own pixel.
  task automatic test_single_image();
    send_pixel_sample(16'h0000);
    send_pixel_sample(16'hFFFF);
    send_pixel_sample(16'h5555);
    send_pixel_sample(16'hAAAA);
  endtask

  // A count of zero behaves as one.
  task automatic test_count_edges();
    write_count(COUNT_W'(0));
    send_pixel_sample(16'h0001);
    send_pixel_sample(16'hFFFE);
  endtask

  // Even counts average the middle pair; odd counts take the middle sample.
  task automatic test_even_odd_median();
    write_count(COUNT_W'(2));
    send_pixel_sample(16'hFFFF);
    send_pixel_sample(16'hFFFF);
    send_pixel_sample(16'h0000);
    send_pixel_sample(16'h0001);
    write_count(COUNT_W'(3));
    send_pixel_sample(16'd30000);
    send_pixel_sample(16'd10000);
    send_pixel_sample(16'd20000);
  endtask

  // Repeated values must not disturb the median or the mean.
  task automatic test_equal_samples();
    send_pixel_sample(16'd7);
    send_pixel_sample(16'd7);
    send_pixel_sample(16'd7);
    write_count(COUNT_W'(4));
    send_pixel_sample(16'd9);
    send_pixel_sample(16'd9);
    send_pixel_sample(16'd3);
    send_pixel_sample(16'd9);
  endtask

  // A register write in the middle of a pixel drops the partial pixel.
  task automatic test_mid_pixel_write();
    send_pixel_sample(16'hFFFF);
    send_pixel_sample(16'hFFFF);
    write_count(COUNT_W'(1));
    send_pixel_sample(16'd5);
  endtask

  // Hold the receiver off so the block fills and stalls its input.
  task automatic test_backpressure();
    write_count(COUNT_W'(2));
    @(posedge clk);
    hold_cycles = 200;
    steady      = 1'b1;
    for (int p = 0; p < 10; p++) send_stack(2, MIX_UNIFORM);
    steady = 1'b0;
    drain_results();
  endtask

  // Random pixels over a range of counts, with occasional abandoned pixels.
  task automatic test_random_stacks();
    int plan_count [14] = '{1, 2, 3, 4, 5, 7, 0, 8, 12, 16, 31, 32, 33, 63};
    int plan_pixels[14] = '{30, 25, 20, 15, 12, 8, 20, 5, 3, 2, 1, 1, 1, 1};
    int count_val;
    int n_pix;
    for (int ph = 0; ph < 15; ph++) begin
      if (ph < 14) begin
        count_val = plan_count[ph];
        n_pix     = plan_pixels[ph];
      end else begin
        count_val = $urandom_range(1, 12);
        n_pix     = 4;
      end
      // Sometimes leave a pixel unfinished before the next setting.
      if ($urandom_range(0, 3) == 0 && stack_depth() > 1) begin
        send_stack($urandom_range(1, stack_depth() - 1), MIX_UNIFORM);
      end
      write_count(COUNT_W'(count_val));
      steady = (ph == 4);
      for (int p = 0; p < n_pix; p++) begin
        send_stack(stack_depth(), mix_t'($urandom_range(0, 4)));
      end
      steady = 1'b0;
    end
  endtask

  // Stimulus sequence.
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    count_reg  = COUNT_W'(1);
    stack_sum  = '0;
    stack_fill = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_image();
    test_count_edges();
    test_even_odd_median();
    test_equal_samples();
    test_mid_pixel_write();
    test_backpressure();
    test_random_stacks();
    drain_results();

    $display("Checked %0d fused pixels from %0d samples over %0d count writes.",
             pixels_fused, samples_sent, cfg_writes);
    $display("Sample input was held off for %0d cycles; %0d mismatches seen.",
             in_stall_cycles, mismatches);
    if (mismatches == 0 && fused_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/smmf_pkg.sv
hdl/smmf_cell.sv
hdl/smmf_div.sv
hdl/stack_median_mean_fuser_unit.sv
verif/tb.sv
